// File: sv/truth_table_perm_canonical_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the permutation canonical-form core
// Clocked, reset-qualified implication checks shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef TRUTH_TABLE_PERM_CANONICAL_CORE_ASSERT_SVH
`define TRUTH_TABLE_PERM_CANONICAL_CORE_ASSERT_SVH

// Same-cycle implication
`define TTPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttpc_pkg.sv
// ---------------------------------------------------------------------------
// ttpc_pkg
// Shared widths, controller states and command/status types of the core.
// ---------------------------------------------------------------------------
package ttpc_pkg;

    // Variable-count field width
    localparam int K_W   = 3;
    // Truth table width (64 rows for six variables)
    localparam int T_W   = 64;
    // Row index width
    localparam int SRC_W = 6;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new item, reset search
        logic step;     // evaluate one permutation, advance order
        logic publish;  // copy best table into output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // current permutation is the final one
    } t_dp_sts;

endpackage

// File: sv/ttpc_datapath.sv
// ---------------------------------------------------------------------------
// ttpc_datapath
// Holds the table, the current input permutation and the running minimum.
// Each step builds one permuted table, keeps the smaller value and moves
// the permutation to its lexicographic successor.
// ---------------------------------------------------------------------------
module ttpc_datapath #(
    parameter int MAX_VARS = 6
) (
    input  logic                        i_clk,
    input  ttpc_pkg::t_dp_cmd           i_cmd,
    input  logic [ttpc_pkg::K_W-1:0]    i_num_vars,
    input  logic [ttpc_pkg::T_W-1:0]    i_truth_table,
    output ttpc_pkg::t_dp_sts           o_sts,
    output logic [ttpc_pkg::T_W-1:0]    o_canonical_table
);

    localparam int PW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int KW = ttpc_pkg::K_W;
    localparam int TW = ttpc_pkg::T_W;

    logic [TW-1:0] r_table;
    logic [KW-1:0] r_k;
    logic [PW-1:0] r_perm [MAX_VARS];
    logic [TW-1:0] r_best;
    logic [TW-1:0] r_out;

    logic [KW-1:0] k_sat;
    logic [TW-1:0] cand;
    logic [TW-1:0] best_min;
    logic          has_next;
    logic [PW-1:0] n_perm [MAX_VARS];

    // Saturate the variable count
    assign k_sat = (i_num_vars > KW'(MAX_VARS)) ? KW'(MAX_VARS) : i_num_vars;

    // Permuted table: row j reads source row with bit perm[l] = bit l of j
    always_comb begin
        logic [ttpc_pkg::SRC_W-1:0] src;
        cand = '0;
        for (int j = 0; j < TW; j++) begin
            src = '0;
            for (int l = 0; l < MAX_VARS; l++) begin
                if ((KW'(l) < r_k) && (((j >> l) & 1) == 1)) begin
                    src[r_perm[l]] = 1'b1;
                end
            end
            cand[j] = (j < (1 << r_k)) ? r_table[src] : 1'b0;
        end
    end

    assign best_min = (cand < r_best) ? cand : r_best;

    // Lexicographic successor of the first k entries
    always_comb begin
        logic [KW-1:0] piv;
        logic [KW-1:0] piv_m1;
        logic [KW-1:0] sel;
        logic [KW:0]   ri;
        logic [PW-1:0] s [MAX_VARS];
        has_next = 1'b0;
        piv      = KW'(1);
        ri       = '0;
        for (int i = 1; i < MAX_VARS; i++) begin
            if ((KW'(i) < r_k) && (r_perm[i-1] < r_perm[i])) begin
                has_next = 1'b1;
                piv      = KW'(i);
            end
        end
        piv_m1 = piv - KW'(1);
        // rightmost entry above the pivot value
        sel = '0;
        for (int jj = 0; jj < MAX_VARS; jj++) begin
            if ((KW'(jj) >= piv) && (KW'(jj) < r_k)
                && (r_perm[jj] > r_perm[piv_m1[PW-1:0]])) begin
                sel = KW'(jj);
            end
        end
        // swap pivot with selected entry
        for (int p = 0; p < MAX_VARS; p++) begin
            s[p] = r_perm[p];
        end
        s[piv_m1[PW-1:0]] = r_perm[sel[PW-1:0]];
        s[sel[PW-1:0]]    = r_perm[piv_m1[PW-1:0]];
        // reverse the suffix after the pivot
        for (int p = 0; p < MAX_VARS; p++) begin
            if ((KW'(p) < piv) || (KW'(p) >= r_k)) begin
                n_perm[p] = s[p];
            end else begin
                ri = {1'b0, r_k} + {1'b0, piv} - (KW+1)'(1) - (KW+1)'(p);
                n_perm[p] = s[ri[PW-1:0]];
            end
        end
    end

    assign o_sts.last = !has_next;

    // Search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_table <= i_truth_table;
            r_k     <= k_sat;
            r_best  <= '1;
            for (int p = 0; p < MAX_VARS; p++) begin
                r_perm[p] <= PW'(p);
            end
        end else if (i_cmd.step) begin
            r_best <= best_min;
            for (int p = 0; p < MAX_VARS; p++) begin
                r_perm[p] <= n_perm[p];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= r_best;
        end
    end

    assign o_canonical_table = r_out;

endmodule

// File: sv/ttpc_ctrl.sv
// ---------------------------------------------------------------------------
// ttpc_ctrl
// Sequencer for the permutation search and owner of the output valid flag.
// ---------------------------------------------------------------------------
module ttpc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  ttpc_pkg::t_dp_sts   i_sts,
    output ttpc_pkg::t_dp_cmd   o_cmd
);

    ttpc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_ready;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_ready       = 1'b0;
        case (r_state)
            ttpc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttpc_pkg::S_RUN;
                end
            end
            ttpc_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ttpc_pkg::S_FLUSH;
                end
            end
            ttpc_pkg::S_FLUSH: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ttpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttpc_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on publish, cleared on transfer
    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttpc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: sv/truth_table_perm_canonical_core.sv
// ---------------------------------------------------------------------------
// truth_table_perm_canonical_core
// Permutation-class canonical form of a Boolean function of up to six inputs.
// ---------------------------------------------------------------------------
// An item is a truth table and a variable count k (saturated to MAX_VARS).
// The core walks all k! input permutations in lexicographic order, one per
// cycle, and returns the smallest permuted table; bits at or above 2^k are
// zero. Zero or one variable counts as a single permutation. An item goes
// through the input transfer, one search step per permutation in the
// permute-and-compare datapath, and a move of the result into the output
// register. The next input can be taken in the same cycle that the result
// becomes valid. The output register lets the next item be taken while a
// result still waits for its transfer; a search that ends while the
// previous result is still unclaimed stalls until that result's transfer.
// ---------------------------------------------------------------------------
`include "truth_table_perm_canonical_core_assert.svh"

module truth_table_perm_canonical_core #(
    parameter int MAX_VARS = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ttpc_pkg::K_W-1:0]    i_num_vars,
    input  logic [ttpc_pkg::T_W-1:0]    i_truth_table,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ttpc_pkg::T_W-1:0]    o_canonical_table
);

    ttpc_pkg::t_dp_cmd dp_cmd;
    ttpc_pkg::t_dp_sts dp_sts;

    // Sequencer
    ttpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // Permute-and-compare datapath
    ttpc_datapath #(
        .MAX_VARS (MAX_VARS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_cmd             (dp_cmd),
        .i_num_vars        (i_num_vars),
        .i_truth_table     (i_truth_table),
        .o_sts             (dp_sts),
        .o_canonical_table (o_canonical_table)
    );

    // Checks
    `TTPC_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready after input transfer")
    `TTPC_ASSERT_NEXT(a_publish_valid, i_clk, i_rst_n, dp_cmd.publish, o_valid, "publish did not raise valid")
    `TTPC_ASSERT_SAME(a_cmd_excl, i_clk, i_rst_n, 1'b1, $onehot0({dp_cmd.load, dp_cmd.step, dp_cmd.publish}), "commands overlap")

endmodule

// File: verif/truth_table_perm_canonical_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// truth_table_perm_canonical_core_tb
// Self-checking bench for the permutation canonical-form core. A clocked
// driver presents truth tables queued by the stimulus block, and the monitor
// computes the smallest table over all input permutations for each transfer.
// It then checks every output transfer against the oldest such prediction.
// Both sides idle at random, with one long output hold-off and four drains.
// ---------------------------------------------------------------------------
module truth_table_perm_canonical_core_tb;

    localparam int K_W       = ttpc_pkg::K_W;
    localparam int T_W       = ttpc_pkg::T_W;
    localparam int MAX_VARS  = 6;
    localparam int N_RANDOM  = 810;
    localparam int HOLD_AT   = 250;   // transfers before the long output hold-off
    localparam int HOLD_LEN  = 2000;  // cycles of the hold-off
    localparam int SETTLE    = 750;   // settling wait after the last result

    typedef struct {
        logic [K_W-1:0] vars;
        logic [T_W-1:0] tt;
        bit             drain;  // wait for all results before presenting
    } t_func_item;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    logic [K_W-1:0] i_num_vars;
    logic [T_W-1:0] i_truth_table;
    logic           o_valid;
    logic           i_ready;
    logic [T_W-1:0] o_canonical_table;

    t_func_item     func_queue[$];
    logic [T_W-1:0] canon_queue[$];
    int             n_taken;
    int             n_total;
    int             n_errors;
    int             tx_gap;
    int             rx_gap;
    logic           in_took;
    logic           hold_rx;
    logic           calm;

    truth_table_perm_canonical_core #(
        .MAX_VARS(MAX_VARS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_num_vars       (i_num_vars),
        .i_truth_table    (i_truth_table),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_canonical_table(o_canonical_table)
    );

    // Smallest table over all orderings of the k inputs
    function automatic logic [T_W-1:0] min_perm_table(input logic [K_W-1:0] vars,
                                                      input logic [T_W-1:0] tt);
        int             k;
        int             ord[6];
        int             row, l, src, a, b, t;
        bit             more;
        logic [T_W-1:0] best;
        logic [T_W-1:0] cand;
        k = (int'(vars) > MAX_VARS) ? MAX_VARS : int'(vars);
        for (l = 0; l < 6; l++) ord[l] = l;
        best = '1;
        more = 1'b1;
        while (more) begin
            cand = '0;
            for (row = 0; row < (1 << k); row++) begin
                src = 0;
                for (l = 0; l < k; l++)
                    if ((row >> l) & 1) src |= 1 << ord[l];
                cand[row] = tt[src];
            end
            if (cand < best) best = cand;
            // lexicographic successor of ord[0..k-1]
            a = k - 1;
            while (a > 0 && ord[a-1] > ord[a]) a--;
            if (a <= 0) begin
                more = 1'b0;
            end else begin
                b = k - 1;
                while (ord[b] < ord[a-1]) b--;
                t = ord[a-1]; ord[a-1] = ord[b]; ord[b] = t;
                b = k - 1;
                while (a < b) begin
                    t = ord[a]; ord[a] = ord[b]; ord[b] = t;
                    a++;
                    b--;
                end
            end
        end
        return best;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [T_W-1:0] rand_table();
        logic [T_W-1:0] v;
        int             r;
        v = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        case (r)
            0: v = 64'd1 << $urandom_range(0, 63);
            1: v = ~(64'd1 << $urandom_range(0, 63));
            2: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            3: v = v | {$urandom, $urandom} | {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_func(input logic [K_W-1:0] vars, input logic [T_W-1:0] tt,
                            input bit drain);
        t_func_item it;
        it.vars  = vars;
        it.tt    = tt;
        it.drain = drain;
        func_queue.insert(func_queue.size(), it);
        n_total++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Quiet stretches with no idling on either side
    always_comb calm = ((n_taken / 128) % 3) == 1;

    // Input driver: holds each item until its transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_took) begin
                // still waiting for the transfer
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (func_queue.size() != 0 &&
                         !(func_queue[0].drain && canon_queue.size() != 0)) begin
                i_valid       <= 1'b1;
                i_num_vars    <= func_queue[0].vars;
                i_truth_table <= func_queue[0].tt;
                func_queue.pop_front();
                if (!calm) tx_gap = gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_rx) begin
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_gap = gap_len();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                canon_queue.insert(canon_queue.size(),
                                   min_perm_table(i_num_vars, i_truth_table));
                n_taken <= n_taken + 1;
            end
            if (o_valid && i_ready) begin
                if (canon_queue.size() == 0) begin
                    $error("o_canonical_table: transfer with nothing expected, actual %h",
                           o_canonical_table);
                    n_errors++;
                end else begin
                    if (o_canonical_table !== canon_queue[0]) begin
                        $error("o_canonical_table: expected %h, actual %h",
                               canon_queue[0], o_canonical_table);
                        n_errors++;
                    end
                    canon_queue.pop_front();
                end
            end
        end
    end

    // Long output hold-off while the sender keeps offering
    initial begin
        hold_rx = 1'b0;
        while (n_taken < HOLD_AT) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int               r;
        logic [K_W-1:0]   vars;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_num_vars    = '0;
        i_truth_table = '0;
        n_taken       = 0;
        n_total       = 0;
        n_errors      = 0;
        tx_gap        = 0;
        rx_gap        = 0;

        // directed: no variables, extremes, known functions, saturation, high bits
        add_func(3'd0, 64'h0, 1'b0);
        add_func(3'd0, 64'h1, 1'b0);
        add_func(3'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        add_func(3'd1, 64'h2, 1'b0);
        add_func(3'd1, 64'h1, 1'b0);
        add_func(3'd2, 64'h4, 1'b0);
        add_func(3'd2, 64'hFFFF_FFFF_FFFF_FFF4, 1'b0);
        add_func(3'd3, 64'hE8, 1'b0);
        add_func(3'd3, 64'h96, 1'b0);
        add_func(3'd3, 64'hDEAD_BEEF_0000_0017, 1'b0);
        add_func(3'd4, 64'h8000, 1'b0);
        add_func(3'd4, 64'h0002, 1'b0);
        add_func(3'd5, 64'h0001_0000, 1'b0);
        add_func(3'd5, 64'hFFFF_FFFF_CAFE_F00D, 1'b0);
        add_func(3'd6, 64'h0, 1'b0);
        add_func(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_func(3'd6, 64'h8000_0000_0000_0000, 1'b0);
        add_func(3'd6, 64'h0000_0000_0000_0002, 1'b0);
        add_func(3'd6, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_func(3'd6, 64'h0123_4567_89AB_CDEF, 1'b0);
        add_func(3'd7, 64'hFEDC_BA98_7654_3210, 1'b0);
        add_func(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

        // random: mostly small counts, some full six-variable searches
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12)      vars = 3'd6;
            else if (r < 16) vars = 3'd7;
            else             vars = K_W'($urandom_range(0, 5));
            add_func(vars, rand_table(), (n % 200) == 199);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total) @(negedge i_clk);
        while (canon_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
